[sv/gww_pkg.sv]
// Shared constants, types and helpers for the greedy word wrap block.
package gww_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int IDX_W     = $clog2(MAX_WIDTH);
  localparam int FILL_W    = IDX_W + 1;
  localparam int BYTE_W    = 8;

  localparam logic [FILL_W-1:0] WIDTH_RESET = FILL_W'(40);
  localparam logic [FILL_W-1:0] WIDTH_MAX   = FILL_W'(MAX_WIDTH);
  localparam logic [FILL_W-1:0] WIDTH_MIN   = FILL_W'(1);

  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

  // Control word broadcast along the chain of cells.
  typedef struct packed {
    logic              shift;
    logic              load;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } chain_ctrl_t;

  // Control word seen by one cell.
  typedef struct packed {
    logic              shift;
    logic              load;
    logic [BYTE_W-1:0] data;
  } cell_ctrl_t;

  function automatic logic is_delim(input logic [BYTE_W-1:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_NEWLINE);
  endfunction

endpackage

[sv/gww_cell.sv]
// One byte cell of the line chain: load in place or take the right neighbor's byte.
module gww_cell (
  input  logic                              clk,
  input  gww_pkg::cell_ctrl_t               ctl,
  input  logic [gww_pkg::BYTE_W-1:0]        right_byte,
  output logic [gww_pkg::BYTE_W-1:0]        cell_byte
);

  logic [gww_pkg::BYTE_W-1:0] held;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      held <= ctl.data;
    end else if (ctl.shift) begin
      held <= right_byte;
    end
  end

  assign cell_byte = held;

endmodule

[sv/gww_chain.sv]
// Row of byte cells holding the current line; shifts toward cell 0 to drain.
module gww_chain (
  input  logic                         clk,
  input  gww_pkg::chain_ctrl_t         ctl,
  output logic [gww_pkg::BYTE_W-1:0]   head_byte
);

  logic [gww_pkg::BYTE_W-1:0] bytes [gww_pkg::MAX_WIDTH];

  for (genvar i = 0; i < gww_pkg::MAX_WIDTH; i++) begin : g_cell
    gww_pkg::cell_ctrl_t        cctl;
    logic [gww_pkg::BYTE_W-1:0] right;

    always_comb begin
      cctl.shift = ctl.shift;
      cctl.load  = ctl.load && (ctl.idx == gww_pkg::IDX_W'(i));
      cctl.data  = ctl.data;
    end

    if (i == gww_pkg::MAX_WIDTH - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = bytes[i+1];
    end

    gww_cell u_cell (
      .clk        (clk),
      .ctl        (cctl),
      .right_byte (right),
      .cell_byte  (bytes[i])
    );
  end

  assign head_byte = bytes[0];

endmodule

[sv/greedy_word_wrap_core.sv]
// Top level of the greedy word wrap block: control sequencer over the byte chain.
//
// Usage: text enters one byte per word on the s_axis channel, tlast marking the
// final byte of a text. Wrapped lines leave one byte per word on m_axis; tlast
// marks the last byte of a line and tuser marks the last word caused by one
// input byte. cfg_we/cfg_wdata set the line width (1..64, reset 40; 0 acts as
// 1 and values above 64 act as 64); write it only while the block is idle.
//
// Flow: a byte that closes no line is taken at once and the next byte can
// follow directly. Otherwise the block takes the byte, emits the line's bytes
// one by one out of cell 0 and then leaves the drain; a break also drops the
// break delimiter (when the line is cut there) and then places the new byte,
// and a further line that this byte closes is drained the same way. Draining
// through cell 0 limits how fast text passes.
//
// Reset clears the fill count, break tracking and output valid, and loads the
// width register with 40. The cells themselves are not cleared. When the
// receiver stalls, the output register holds its word and the drain waits;
// a new text byte is taken only once the previous one is fully handled.
module greedy_word_wrap_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,       // wrap_width
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] text_byte
  input  logic       s_axis_tlast,    // text_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_byte
  output logic       m_axis_tlast,    // line_done
  output logic       m_axis_tuser     // [0] run_last
);

  localparam int FW = gww_pkg::FILL_W;
  localparam int IW = gww_pkg::IDX_W;
  localparam int BW = gww_pkg::BYTE_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DRAIN  = 2'd1;
  localparam logic [1:0] ST_APPEND = 2'd2;

  logic [1:0]    state, state_next;
  logic [FW-1:0] wrap_width;
  logic [FW-1:0] fill, fill_next;
  logic [IW-1:0] bp, bp_next;
  logic          bv, bv_next;
  logic [FW-1:0] cnt, cnt_next;
  logic          drop, drop_next;
  logic          tail, tail_next;
  logic          final_line, final_line_next;

  // Item held across a break drain.
  logic [BW-1:0] item_byte, item_byte_next;
  logic          app_q, app_q_next;
  logic [FW-1:0] f2_q, f2_q_next;
  logic          bv2_q, bv2_q_next;
  logic [IW-1:0] bp2_q, bp2_q_next;
  logic          later_q, later_q_next;

  // Output register.
  logic          out_valid, out_valid_next;
  logic [BW-1:0] out_byte, out_byte_next;
  logic          out_last, out_last_next;
  logic          out_user, out_user_next;

  gww_pkg::chain_ctrl_t chain_ctl;
  logic [BW-1:0]        head_byte;

  gww_chain u_chain (
    .clk       (clk),
    .ctl       (chain_ctl),
    .head_byte (head_byte)
  );

  // Effective width, clamped to 1..MAX_WIDTH.
  logic [FW-1:0] w_eff;
  always_comb begin
    if (wrap_width == '0) begin
      w_eff = gww_pkg::WIDTH_MIN;
    end else if (wrap_width > gww_pkg::WIDTH_MAX) begin
      w_eff = gww_pkg::WIDTH_MAX;
    end else begin
      w_eff = wrap_width;
    end
  end

  // Break decision for the byte at the input, taken from the current line state.
  logic          in_d, full, a_all, a_part, app, bv1, bv2, later;
  logic [FW-1:0] keep, f1, f2;
  logic [IW-1:0] bp2;

  always_comb begin
    in_d   = gww_pkg::is_delim(s_axis_tdata);
    full   = fill >= w_eff;
    a_all  = full && (in_d || !bv);
    a_part = full && !in_d && bv;
    keep   = fill - {1'b0, bp} - FW'(1);
    if (a_all) begin
      f1 = '0;
    end else if (a_part) begin
      f1 = keep;
    end else begin
      f1 = fill;
    end
    bv1   = full ? 1'b0 : bv;
    app   = !(full && in_d) && !((f1 == '0) && in_d) && !f1[FW-1];
    f2    = f1 + FW'(app);
    bv2   = bv1 | (app & in_d);
    bp2   = (app && in_d) ? f1[IW-1:0] : bp;
    later = ((f2 >= w_eff) && !bv2) || (s_axis_tlast && (f2 != '0));
  end

  logic accept, out_free;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    bp_next         = bp;
    bv_next         = bv;
    cnt_next        = cnt;
    drop_next       = drop;
    tail_next       = tail;
    final_line_next = final_line;
    item_byte_next  = item_byte;
    app_q_next      = app_q;
    f2_q_next       = f2_q;
    bv2_q_next      = bv2_q;
    bp2_q_next      = bp2_q;
    later_q_next    = later_q;
    out_byte_next   = out_byte;
    out_last_next   = out_last;
    out_user_next   = out_user;
    out_valid_next  = out_valid && !m_axis_tready;
    chain_ctl       = '{shift: 1'b0, load: 1'b0, idx: fill[IW-1:0], data: s_axis_tdata};

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            // Break first: drain the line (or the part before the last
            // delimiter), then place the byte if it is not a delimiter.
            cnt_next        = a_all ? fill : {1'b0, bp};
            drop_next       = a_part;
            tail_next       = 1'b1;
            final_line_next = !later;
            fill_next       = f1;
            bv_next         = 1'b0;
            item_byte_next  = s_axis_tdata;
            app_q_next      = app;
            f2_q_next       = f2;
            bv2_q_next      = bv2;
            bp2_q_next      = bp2;
            later_q_next    = later;
            state_next      = ST_DRAIN;
          end else begin
            chain_ctl.load = app;
            if (later) begin
              // Line reached the width with no delimiter, or text ended.
              fill_next       = '0;
              bv_next         = 1'b0;
              cnt_next        = f2;
              drop_next       = 1'b0;
              tail_next       = 1'b0;
              final_line_next = 1'b1;
              state_next      = ST_DRAIN;
            end else begin
              fill_next = f2;
              bv_next   = bv2;
              bp_next   = bp2;
            end
          end
        end
      end

      ST_APPEND: begin
        chain_ctl.load = app_q;
        chain_ctl.data = item_byte;
        if (later_q) begin
          fill_next       = '0;
          bv_next         = 1'b0;
          cnt_next        = f2_q;
          drop_next       = 1'b0;
          tail_next       = 1'b0;
          final_line_next = 1'b1;
          state_next      = ST_DRAIN;
        end else begin
          fill_next  = f2_q;
          bv_next    = bv2_q;
          bp_next    = bp2_q;
          state_next = ST_IDLE;
        end
      end

      ST_DRAIN: begin
        if (cnt != '0) begin
          // Advance one byte out of cell 0 when the output slot frees.
          if (out_free) begin
            chain_ctl.shift = 1'b1;
            out_valid_next  = 1'b1;
            out_byte_next   = head_byte;
            out_last_next   = (cnt == FW'(1));
            out_user_next   = (cnt == FW'(1)) && final_line;
            cnt_next        = cnt - FW'(1);
          end
        end else if (drop) begin
          // Drop the break delimiter; carried bytes land at cell 0.
          chain_ctl.shift = 1'b1;
          drop_next       = 1'b0;
        end else begin
          state_next = tail ? ST_APPEND : ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wrap_width <= gww_pkg::WIDTH_RESET;
      fill       <= '0;
      bp         <= '0;
      bv         <= 1'b0;
      cnt        <= '0;
      drop       <= 1'b0;
      tail       <= 1'b0;
      final_line <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      bp         <= bp_next;
      bv         <= bv_next;
      cnt        <= cnt_next;
      drop       <= drop_next;
      tail       <= tail_next;
      final_line <= final_line_next;
      out_valid  <= out_valid_next;
      if (cfg_we) begin
        wrap_width <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_byte <= item_byte_next;
    app_q     <= app_q_next;
    f2_q      <= f2_q_next;
    bv2_q     <= bv2_q_next;
    bp2_q     <= bp2_q_next;
    later_q   <= later_q_next;
    out_byte  <= out_byte_next;
    out_last  <= out_last_next;
    out_user  <= out_user_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_user;

  // The last word of an item always closes a line.
  a_run_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("run_last without line_done");

  // A held delimiter always lies inside the filled part of the chain.
  a_break_inside: assert property (@(posedge clk) disable iff (rst)
    bv |-> ({1'b0, bp} < fill))
    else $error("break position outside the line");

  // Fill and drain counts never pass the chain length.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill <= gww_pkg::WIDTH_MAX) && (cnt <= gww_pkg::WIDTH_MAX))
    else $error("fill or drain count beyond chain length");

  // An emitted word leaves the drain count one lower.
  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DRAIN) && (cnt != '0) && out_free) |=> (cnt == $past(cnt) - FW'(1)))
    else $error("drain count did not advance");

endmodule
